[hw/rtl/rtti_pkg.sv]
// rtti_pkg: radix codes, character constants and digit decode for the
// radix text-to-integer parser. No dependencies.
`timescale 1ns / 1ps

package rtti_pkg;

  // Radix modes
  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_BIN = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_OCT = 2'd3;

  // Characters
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_H     = 8'h68;  // 'h'
  localparam logic [7:0] CH_O     = 8'h6F;  // 'o'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] UPPER_OFS = 8'd55;
  localparam logic [7:0] LOWER_OFS = 8'd87;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Digit value of c under the given radix mode
  function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] mode);
    digit_t     d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      d.ok = 1'b1;
    end else if (mode == MODE_HEX && c >= CH_UA && c <= CH_UF) begin
      diff = c - UPPER_OFS;
      d.ok = 1'b1;
    end else if (mode == MODE_HEX && c >= CH_LA && c <= CH_LF) begin
      diff = c - LOWER_OFS;
      d.ok = 1'b1;
    end
    d.val = diff[3:0];
    if (mode == MODE_BIN && d.val > 4'd1) d.ok = 1'b0;
    if (mode == MODE_OCT && d.val > 4'd7) d.ok = 1'b0;
    return d;
  endfunction

endpackage

[hw/rtl/radix_text_to_integer.sv]
// radix_text_to_integer: character-serial number token parser, top level.
// Depends on rtti_pkg.
`timescale 1ns / 1ps

// Channel  Ports                               Direction  Request
// in       in_valid/in_ready, in_char_code,    input      one character
//          in_last
// out      out_valid/out_ready, out_value,     output     one parsed token
//          out_error
//
// One character is taken per cycle while in_ready is high. The accumulator and
// token state update in the cycle a character is taken; a token's last
// character loads a finish register, which then forms the signed value (negate
// or complement) into the output register when the path advances. Reset (rst_n
// low, synchronous) returns the parser to waiting for a radix letter and
// empties both stages. A stall on out holds the whole path, so in_ready drops
// only while out is full and not being taken.

module radix_text_to_integer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic        out_error
);

  // Token phase
  localparam logic [1:0] PH_RADIX = 2'd0;  // waiting for radix letter
  localparam logic [1:0] PH_FIRST = 2'd1;  // waiting for first body character
  localparam logic [1:0] PH_BODY  = 2'd2;  // inside the body

  // Token state
  logic [1:0]  phase_r,  phase_nxt;
  logic [1:0]  mode_r,   mode_nxt;
  logic        neg_r,    neg_nxt;
  logic [63:0] acc_r,    acc_nxt;
  logic        fault_r,  fault_nxt;

  // Finish stage: a completed token awaiting sign resolution
  logic        fin_valid_r;
  logic [63:0] fin_acc_r;
  logic        fin_neg_r;
  logic        fin_dec_r;
  logic        fin_err_r;

  // Output register
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_error_r;

  logic              adv;
  logic              take;
  rtti_pkg::digit_t  dg;
  logic              first;
  logic [63:0]       value_c;

  // Whole path moves unless a result sits unread
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  assign dg    = rtti_pkg::digit_of(in_char_code, mode_r);
  assign first = (phase_r == PH_FIRST);

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    fault_nxt = fault_r;
    if (fault_r) begin
      // skip to end of token
    end else if (phase_r == PH_RADIX) begin
      priority if (in_char_code == rtti_pkg::CH_D) mode_nxt = rtti_pkg::MODE_DEC;
      else if (in_char_code == rtti_pkg::CH_B) mode_nxt = rtti_pkg::MODE_BIN;
      else if (in_char_code == rtti_pkg::CH_H) mode_nxt = rtti_pkg::MODE_HEX;
      else if (in_char_code == rtti_pkg::CH_O) mode_nxt = rtti_pkg::MODE_OCT;
      else fault_nxt = 1'b1;
      phase_nxt = PH_FIRST;
      neg_nxt   = 1'b0;
      acc_nxt   = '0;
      if (in_last) fault_nxt = 1'b1;   // radix letter alone: empty body
    end else if (first && mode_r == rtti_pkg::MODE_DEC &&
                 in_char_code == rtti_pkg::CH_MINUS) begin
      neg_nxt   = 1'b1;
      phase_nxt = PH_BODY;
    end else if (!dg.ok) begin
      fault_nxt = 1'b1;
    end else begin
      phase_nxt = PH_BODY;
      unique case (mode_r)
        rtti_pkg::MODE_DEC: begin
          acc_nxt = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, dg.val};
        end
        rtti_pkg::MODE_BIN: begin
          neg_nxt = neg_r || (first && dg.val[0]);
          acc_nxt = {acc_r[62:0], dg.val[0] ^ neg_nxt};
        end
        rtti_pkg::MODE_HEX: begin
          neg_nxt = neg_r || (first && dg.val[3]);
          acc_nxt = {acc_r[59:0], neg_nxt ? ~dg.val : dg.val};
        end
        default: begin
          // octal: sign-bearing lead digit d seeds 3 - d
          if (first && dg.val[2:1] != 2'b00) begin
            neg_nxt = 1'b1;
            acc_nxt = 64'd3 - {60'd0, dg.val};
          end else begin
            acc_nxt = {acc_r[60:0], neg_r ? ~dg.val[2:0] : dg.val[2:0]};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RADIX;
      mode_r  <= rtti_pkg::MODE_DEC;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      fault_r <= 1'b0;
    end else if (take) begin
      if (in_last) begin
        phase_r <= PH_RADIX;
        mode_r  <= rtti_pkg::MODE_DEC;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        fault_r <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        mode_r  <= mode_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        fault_r <= fault_nxt;
      end
    end
  end

  // Finish stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (adv) begin
      fin_valid_r <= take && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      fin_acc_r <= acc_nxt;
      fin_neg_r <= neg_nxt;
      fin_dec_r <= (mode_nxt == rtti_pkg::MODE_DEC);
      fin_err_r <= fault_nxt;
    end
  end

  // Sign resolution: decimal negates, others take -(acc + 1) = ~acc
  always_comb begin
    priority if (fin_err_r) value_c = '0;
    else if (!fin_neg_r)    value_c = fin_acc_r;
    else if (fin_dec_r)     value_c = 64'd0 - fin_acc_r;
    else                    value_c = ~fin_acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid_r) begin
      out_value_r <= value_c;
      out_error_r <= fin_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule

[tb/sv/radix_text_to_integer_checker.sv]
// Checker for radix_text_to_integer: watches both request channels, keeps its
// own token parser and compares each parsed result field by field.
// Depends on rtti_pkg for radix modes and character constants.
`timescale 1ns / 1ps

module radix_text_to_integer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_value,
  input  logic        out_error,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {PH_RADIX, PH_FIRST, PH_BODY} parse_phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } token_result_t;

  parse_phase_t  tok_phase;
  logic [1:0]    tok_mode;
  logic          tok_neg;
  logic [63:0]   tok_acc;
  logic          tok_fault;
  token_result_t parsed_tokens[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_token();
    tok_phase = PH_RADIX;
    tok_mode  = rtti_pkg::MODE_DEC;
    tok_neg   = 1'b0;
    tok_acc   = '0;
    tok_fault = 1'b0;
  endtask

  // -1 when c is not a digit of the radix
  function automatic int digit_value(input logic [7:0] c, input logic [1:0] mode);
    int d;
    d = -1;
    if (c >= rtti_pkg::CH_0 && c <= rtti_pkg::CH_9) begin
      d = int'(c) - int'(rtti_pkg::CH_0);
    end else if (mode == rtti_pkg::MODE_HEX && c >= rtti_pkg::CH_UA &&
                 c <= rtti_pkg::CH_UF) begin
      d = int'(c) - int'(rtti_pkg::UPPER_OFS);
    end else if (mode == rtti_pkg::MODE_HEX && c >= rtti_pkg::CH_LA &&
                 c <= rtti_pkg::CH_LF) begin
      d = int'(c) - int'(rtti_pkg::LOWER_OFS);
    end
    if (mode == rtti_pkg::MODE_BIN && d > 1) d = -1;
    if (mode == rtti_pkg::MODE_OCT && d > 7) d = -1;
    return d;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic is_last);
    int            d;
    logic [63:0]   u;
    logic          lead;
    token_result_t r;
    if (tok_fault) begin
      // swallow the rest of a broken token
    end else if (tok_phase == PH_RADIX) begin
      case (c)
        rtti_pkg::CH_D: tok_mode = rtti_pkg::MODE_DEC;
        rtti_pkg::CH_B: tok_mode = rtti_pkg::MODE_BIN;
        rtti_pkg::CH_H: tok_mode = rtti_pkg::MODE_HEX;
        rtti_pkg::CH_O: tok_mode = rtti_pkg::MODE_OCT;
        default: tok_fault = 1'b1;
      endcase
      tok_phase = PH_FIRST;
      tok_neg   = 1'b0;
      tok_acc   = '0;
      if (is_last) tok_fault = 1'b1;
    end else if (tok_phase == PH_FIRST && tok_mode == rtti_pkg::MODE_DEC &&
                 c == rtti_pkg::CH_MINUS) begin
      tok_neg   = 1'b1;
      tok_phase = PH_BODY;
    end else begin
      d = digit_value(c, tok_mode);
      if (d < 0) begin
        tok_fault = 1'b1;
      end else begin
        lead      = (tok_phase == PH_FIRST);
        u         = 64'(d);
        tok_phase = PH_BODY;
        case (tok_mode)
          rtti_pkg::MODE_DEC: tok_acc = (tok_acc << 3) + (tok_acc << 1) + u;
          rtti_pkg::MODE_BIN: begin
            if (lead && u == 64'd1) tok_neg = 1'b1;
            tok_acc = (tok_acc << 1) + (tok_neg ? 64'd1 - u : u);
          end
          rtti_pkg::MODE_HEX: begin
            if (lead && u >= 64'd8) tok_neg = 1'b1;
            tok_acc = (tok_acc << 4) + (tok_neg ? 64'd15 - u : u);
          end
          default: begin
            // sign-bearing leading octal digit seeds the complement directly
            if (lead && u >= 64'd2) begin
              tok_neg = 1'b1;
              tok_acc = 64'd3 - u;
            end else begin
              tok_acc = (tok_acc << 3) + (tok_neg ? 64'd7 - u : u);
            end
          end
        endcase
      end
    end

    if (is_last) begin
      r.error = tok_fault;
      if (tok_fault) r.value = '0;
      else if (!tok_neg) r.value = tok_acc;
      else if (tok_mode == rtti_pkg::MODE_DEC) r.value = 64'd0 - tok_acc;
      else r.value = 64'd0 - (tok_acc + 64'd1);
      parsed_tokens.push_back(r);
      clear_token();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_token();
      parsed_tokens.delete();
    end else begin
      if (in_valid && in_ready) parse_char(in_char_code, in_last);
      if (out_valid && out_ready) begin
        if (parsed_tokens.size() == 0) begin
          report_mismatch("unexpected result", out_value, '0);
        end else begin
          if (out_value !== parsed_tokens[0].value)
            report_mismatch("value", out_value, parsed_tokens[0].value);
          if (out_error !== parsed_tokens[0].error)
            report_mismatch("error", 64'(out_error), 64'(parsed_tokens[0].error));
          void'(parsed_tokens.pop_front());
        end
      end
    end
    pending = parsed_tokens.size();
  end

endmodule

[tb/sv/tb_radix_text_to_integer.sv]
// Testbench top for radix_text_to_integer: clock, reset, character stimulus
// and receiver back-pressure; checking is done by radix_text_to_integer_checker.
// Depends on rtti_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_radix_text_to_integer;

  // Rough number of characters to send, and the cycle budget for the run.
  // Budget is far above the slowest legal run (heavy idling on both sides).
  localparam int NUM_CHARS   = 1450;
  localparam int CYCLE_LIMIT = 200000;
  // Quiet cycles after the last result.
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_value;
  logic        out_error;

  int          fail_count;
  int          pending;
  int          cycles;
  int          chars_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic [7:0]  token_chars[$];

  radix_text_to_integer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_error    (out_error)
  );

  radix_text_to_integer_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_error    (out_error),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[radix_text_to_integer] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn on every falling edge so that stalls land
  // on either of the block's finish and output stages.
  always @(negedge clk) begin
    if (rst_n) out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hands one character request to the block. Entered and left on a falling
  // edge; valid stays high from one request to the next unless the sender
  // idles, so it is never dropped and raised within one step.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_char_code = c;
    in_last      = is_last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_chars();
    int i;
    for (i = 0; i < token_chars.size(); i++)
      send_char(token_chars[i], i == token_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    int i;
    token_chars.delete();
    for (i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
    send_chars();
  endtask

  function automatic logic [7:0] radix_letter(input logic [1:0] mode);
    case (mode)
      rtti_pkg::MODE_DEC: return rtti_pkg::CH_D;
      rtti_pkg::MODE_BIN: return rtti_pkg::CH_B;
      rtti_pkg::MODE_HEX: return rtti_pkg::CH_H;
      default:            return rtti_pkg::CH_O;
    endcase
  endfunction

  // A legal digit of the radix; hex letters come in either case.
  function automatic logic [7:0] random_digit(input logic [1:0] mode);
    int d;
    case (mode)
      rtti_pkg::MODE_DEC: d = $urandom_range(0, 9);
      rtti_pkg::MODE_BIN: d = $urandom_range(0, 1);
      rtti_pkg::MODE_HEX: d = $urandom_range(0, 15);
      default:            d = $urandom_range(0, 7);
    endcase
    if (d < 10) return rtti_pkg::CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? rtti_pkg::CH_UA : rtti_pkg::CH_LA) + 8'(d - 10);
  endfunction

  // Fills token_chars with one token. Mostly well-formed tokens with random
  // digits; the rest are corrupted bodies, stray minus signs, empty bodies
  // and unknown radix letters followed by junk.
  task automatic build_token();
    int         kind;
    int         len;
    int         i;
    int         pos;
    logic [1:0] mode;
    token_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      token_chars.push_back(8'($urandom_range(0, 255)));
      len = $urandom_range(0, 5);
      for (i = 0; i < len; i++) token_chars.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 90) begin
      token_chars.push_back(radix_letter(2'($urandom_range(0, 3))));
    end else begin
      mode = 2'($urandom_range(0, 3));
      token_chars.push_back(radix_letter(mode));
      len = $urandom_range(1, 12);
      // now and then a body long enough to wrap the 64-bit accumulator
      if ($urandom_range(0, 9) == 0) begin
        case (mode)
          rtti_pkg::MODE_DEC: len = $urandom_range(18, 22);
          rtti_pkg::MODE_BIN: len = $urandom_range(60, 66);
          rtti_pkg::MODE_HEX: len = $urandom_range(15, 18);
          default:            len = $urandom_range(20, 24);
        endcase
      end
      if (mode == rtti_pkg::MODE_DEC && $urandom_range(0, 3) == 0) begin
        token_chars.push_back(rtti_pkg::CH_MINUS);
        if ($urandom_range(0, 9) == 0) len = 0;
      end
      for (i = 0; i < len; i++) token_chars.push_back(random_digit(mode));
      if (kind >= 87 && mode == rtti_pkg::MODE_DEC) begin
        token_chars.insert($urandom_range(2, token_chars.size()), rtti_pkg::CH_MINUS);
      end else if (kind >= 80) begin
        pos = $urandom_range(0, token_chars.size() - 1);
        token_chars[pos] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = '0;
    in_last        = 1'b0;
    out_ready      = 1'b0;
    chars_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed tokens: empty body, unknown radix with extreme bytes, bare
    // minus, negative decimal, hex in both cases with sign-bearing lead,
    // binary and octal negatives, misplaced minus, digits out of range.
    send_text("d");
    token_chars = {8'hFF, 8'h00};
    send_chars();
    send_text("d-");
    send_text("d-9");
    send_text("h7F");
    send_text("hfa");
    send_text("b1");
    send_text("o7");
    send_text("d1-");
    send_text("b2");
    send_text("o8");

    // Random tokens in four idling phases: none, sender idle, receiver
    // stalling, then light idling on both sides.
    while (chars_sent < NUM_CHARS) begin
      case ((chars_sent * 4) / NUM_CHARS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      build_token();
      send_chars();
    end
    in_valid = 1'b0;

    // Drain: every token must come back, then a few quiet cycles to catch
    // anything spurious.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("[radix_text_to_integer] OK");
    end else begin
      $display("[radix_text_to_integer] ERROR");
    end
    $finish;
  end

endmodule
